/* rtl/mck_pkg.sv */
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, register indexes and the letter code table of the Morse keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W  = 8;
  localparam int UNITS_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int PAT_W   = 4;
  localparam int CNT_W   = 3;
  localparam int SYM_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_GAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP   = 3'd4;

  localparam logic [UNITS_W-1:0] DOT_RESET        = 4'd1;
  localparam logic [UNITS_W-1:0] DASH_RESET       = 4'd3;
  localparam logic [UNITS_W-1:0] SYMBOL_GAP_RESET = 4'd1;
  localparam logic [UNITS_W-1:0] LETTER_GAP_RESET = 4'd3;
  localparam logic [UNITS_W-1:0] WORD_GAP_RESET   = 4'd7;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SPACE,
    KIND_LETTER
  } mck_kind_t;

  typedef enum logic [1:0] {
    SEL_WORD,
    SEL_LETTER,
    SEL_SYMBOL,
    SEL_MARK
  } mck_sel_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    mck_sel_t sel;
    logic     last;
    logic     adv;
    logic     set_ws;
    logic     clr_ws;
  } mck_cmd_t;

  typedef struct packed {
    mck_kind_t kind;
    logic      word_start;
    logic      last_sym;
    logic      out_free;
  } mck_sts_t;

  function automatic logic [UNITS_W-1:0] len_of(input logic [UNITS_W-1:0] v);
    return (v == '0) ? UNITS_W'(1) : v;
  endfunction

  // high nibble: symbol count, low nibble: pattern with bit i set for a dash
  function automatic logic [7:0] code_lookup(input logic [4:0] idx);
    logic [7:0] e;
    unique case (idx)
      5'd0:  e = 8'h22;
      5'd1:  e = 8'h41;
      5'd2:  e = 8'h45;
      5'd3:  e = 8'h31;
      5'd4:  e = 8'h10;
      5'd5:  e = 8'h44;
      5'd6:  e = 8'h33;
      5'd7:  e = 8'h40;
      5'd8:  e = 8'h20;
      5'd9:  e = 8'h4E;
      5'd10: e = 8'h35;
      5'd11: e = 8'h42;
      5'd12: e = 8'h23;
      5'd13: e = 8'h21;
      5'd14: e = 8'h37;
      5'd15: e = 8'h46;
      5'd16: e = 8'h4B;
      5'd17: e = 8'h32;
      5'd18: e = 8'h30;
      5'd19: e = 8'h11;
      5'd20: e = 8'h34;
      5'd21: e = 8'h48;
      5'd22: e = 8'h36;
      5'd23: e = 8'h49;
      5'd24: e = 8'h4D;
      5'd25: e = 8'h43;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

/* rtl/mck_char_if.sv */
// ----------------------------------------------------------------------------
// mck_char_if
// Character channel: one ASCII character per item.
// ----------------------------------------------------------------------------
interface mck_char_if;
  logic                        valid;
  logic                        ready;
  logic [mck_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

/* rtl/mck_interval_if.sv */
// ----------------------------------------------------------------------------
// mck_interval_if
// Interval channel: one lamp interval per item.
// ----------------------------------------------------------------------------
interface mck_interval_if;
  logic                         valid;
  logic                         ready;
  logic                         lamp_on;
  logic [mck_pkg::UNITS_W-1:0]  interval_units;
  logic                         last_interval;

  modport source (output valid, output lamp_on, output interval_units,
                  output last_interval, input ready);
  modport sink   (input valid, input lamp_on, input interval_units,
                  input last_interval, output ready);
endinterface

/* rtl/mck_dp.sv */
// ----------------------------------------------------------------------------
// mck_dp
// Datapath: timing registers, letter decode, symbol state and output register.
// ----------------------------------------------------------------------------
module mck_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mck_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mck_pkg::UNITS_W-1:0]     cfg_data,
  input  logic [mck_pkg::CHAR_W-1:0]      in_char,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_lamp_on,
  output logic [mck_pkg::UNITS_W-1:0]     out_units,
  output logic                            out_last,
  input  mck_pkg::mck_cmd_t               cmd,
  output mck_pkg::mck_sts_t               sts
);

  logic [mck_pkg::UNITS_W-1:0]   dot_r, dash_r, sgap_r, lgap_r, wgap_r;
  logic                          word_start_r;
  logic [mck_pkg::PAT_W-1:0]     symbol_shift_r;
  logic [mck_pkg::CNT_W-1:0]     symbol_count_r;
  logic [mck_pkg::SYM_IDX_W-1:0] idx_r;
  logic                          out_valid_r;
  logic                          lamp_r;
  logic [mck_pkg::UNITS_W-1:0]   units_r;
  logic                          last_r;

  logic [mck_pkg::CHAR_W-1:0]    fold;
  logic                          is_letter;
  logic [4:0]                    letter_idx;
  logic [7:0]                    entry;
  mck_pkg::mck_kind_t            kind;
  logic [mck_pkg::UNITS_W-1:0]   units_sel;

  always_comb begin
    fold = in_char;
    if (in_char >= mck_pkg::CHAR_LOWER_A && in_char <= mck_pkg::CHAR_LOWER_Z) begin
      fold = in_char & ~mck_pkg::CASE_BIT;
    end
    is_letter  = (fold >= mck_pkg::CHAR_UPPER_A) && (fold <= mck_pkg::CHAR_UPPER_Z);
    letter_idx = 5'(fold - mck_pkg::CHAR_UPPER_A);
    entry      = is_letter ? mck_pkg::code_lookup(letter_idx) : 8'h00;
    if (in_char == mck_pkg::CHAR_SPACE) begin
      kind = mck_pkg::KIND_SPACE;
    end else if (is_letter) begin
      kind = mck_pkg::KIND_LETTER;
    end else begin
      kind = mck_pkg::KIND_NONE;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      mck_pkg::SEL_WORD:   units_sel = mck_pkg::len_of(wgap_r);
      mck_pkg::SEL_LETTER: units_sel = mck_pkg::len_of(lgap_r);
      mck_pkg::SEL_SYMBOL: units_sel = mck_pkg::len_of(sgap_r);
      mck_pkg::SEL_MARK:   units_sel = symbol_shift_r[idx_r] ? mck_pkg::len_of(dash_r)
                                                             : mck_pkg::len_of(dot_r);
      default:             units_sel = mck_pkg::len_of(dot_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r          <= mck_pkg::DOT_RESET;
      dash_r         <= mck_pkg::DASH_RESET;
      sgap_r         <= mck_pkg::SYMBOL_GAP_RESET;
      lgap_r         <= mck_pkg::LETTER_GAP_RESET;
      wgap_r         <= mck_pkg::WORD_GAP_RESET;
      word_start_r   <= 1'b1;
      symbol_shift_r <= '0;
      symbol_count_r <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mck_pkg::CFG_DOT:        dot_r  <= cfg_data;
          mck_pkg::CFG_DASH:       dash_r <= cfg_data;
          mck_pkg::CFG_SYMBOL_GAP: sgap_r <= cfg_data;
          mck_pkg::CFG_LETTER_GAP: lgap_r <= cfg_data;
          mck_pkg::CFG_WORD_GAP:   wgap_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && kind == mck_pkg::KIND_LETTER) begin
        symbol_shift_r <= entry[mck_pkg::PAT_W-1:0];
        symbol_count_r <= entry[6:4];
        idx_r          <= '0;
      end else if (cmd.adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.set_ws) begin
        word_start_r <= 1'b1;
      end else if (cmd.clr_ws) begin
        word_start_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      lamp_r  <= (cmd.sel == mck_pkg::SEL_MARK);
      units_r <= units_sel;
      last_r  <= cmd.last;
    end
  end

  assign sts.kind       = kind;
  assign sts.word_start = word_start_r;
  assign sts.last_sym   = ({1'b0, idx_r} == (symbol_count_r - 3'd1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_lamp_on = lamp_r;
  assign out_units   = units_r;
  assign out_last    = last_r;

endmodule

/* rtl/mck_ctrl.sv */
// ----------------------------------------------------------------------------
// mck_ctrl
// Controller: sequences gaps and marks of one character into the datapath.
// ----------------------------------------------------------------------------
module mck_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mck_pkg::mck_sts_t  sts,
  output mck_pkg::mck_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGAP,
    ST_LGAP,
    ST_MARK,
    ST_SGAP
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.sel    = mck_pkg::SEL_WORD;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (sts.kind)
            mck_pkg::KIND_SPACE:  state_nxt = ST_WGAP;
            mck_pkg::KIND_LETTER: state_nxt = sts.word_start ? ST_MARK : ST_LGAP;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WGAP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = mck_pkg::SEL_WORD;
          cmd.last   = 1'b1;
          cmd.set_ws = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_LGAP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = mck_pkg::SEL_LETTER;
          state_nxt = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd.sel = mck_pkg::SEL_MARK;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = sts.last_sym;
          if (sts.last_sym) begin
            cmd.clr_ws = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_SGAP;
          end
        end
      end
      ST_SGAP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = mck_pkg::SEL_SYMBOL;
          state_nxt = ST_MARK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("interval emitted into a full output register");

  a_mark_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && cmd.emit && !sts.last_sym) |=> (state_r == ST_SGAP))
    else $error("missing symbol gap after a non-final mark");

  a_space_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.kind == mck_pkg::KIND_SPACE) |=> (state_r == ST_WGAP))
    else $error("space item did not start a word gap");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE && !cmd.emit))
    else $error("character loaded while intervals pending");

endmodule

/* rtl/morse_code_keyer.sv */
// ----------------------------------------------------------------------------
// morse_code_keyer
// International Morse keyer: one ASCII character in, lamp intervals out.
// ----------------------------------------------------------------------------
// A taken character moves the controller to its first gap or mark state, which
// registers the first interval; then one interval per cycle while the output
// register is free. An unknown character gives no interval.
// The next character is taken once the last interval enters the output register.
// Reset (synchronous, rst_n low): timing registers return to 1/3/1/3/7,
// the next letter starts a word and the output register empties.
module morse_code_keyer (
  input  logic                            clk,
  input  logic                            rst_n,
  mck_char_if.sink                        in_chan,
  mck_interval_if.source                  out_chan,
  input  logic                            cfg_we,
  input  logic [mck_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mck_pkg::UNITS_W-1:0]     cfg_data
);

  mck_pkg::mck_cmd_t cmd;
  mck_pkg::mck_sts_t sts;

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mck_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_char     (in_chan.char_code),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_lamp_on (out_chan.lamp_on),
    .out_units   (out_chan.interval_units),
    .out_last    (out_chan.last_interval),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

/* test/morse_code_keyer_tb.sv */
// ----------------------------------------------------------------------------
// morse_code_keyer_tb
// Self-checking bench for the Morse keyer. Characters go in over the source
// channel and every lamp interval coming out is checked against intervals
// predicted from a dot/dash table kept in the bench. It covers reset timing,
// character edge codes, zero, full and out-of-range register writes, random
// words under random timing, and a long output stall.
// ----------------------------------------------------------------------------
module morse_code_keyer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_REGS      = 5;
  localparam int STALL_CYCLES  = 400;

  typedef struct {
    logic                        lamp_on;
    logic [mck_pkg::UNITS_W-1:0] units;
    logic                        last;
  } interval_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mck_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mck_pkg::UNITS_W-1:0]   cfg_data;

  mck_char_if     char_chan ();
  mck_interval_if ivl_chan ();

  morse_code_keyer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (char_chan),
    .out_chan  (ivl_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  string morse_tab [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };

  logic [mck_pkg::UNITS_W-1:0] timing_reg [NUM_REGS];
  logic                        at_word_start;
  interval_t                   interval_q [$];
  int                          errors = 0;
  bit                          stall_on = 1'b0;
  event                        stall_start;
  bit                          idle_on;
  int                          cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [mck_pkg::UNITS_W-1:0] dit_len(
    input logic [mck_pkg::UNITS_W-1:0] v);
    return (v == '0) ? mck_pkg::UNITS_W'(1) : v;
  endfunction

  function automatic void push_interval(input logic lamp,
                                        input logic [mck_pkg::UNITS_W-1:0] units,
                                        input logic last);
    interval_t iv;
    iv.lamp_on = lamp;
    iv.units   = dit_len(units);
    iv.last    = last;
    interval_q.push_back(iv);
  endfunction

  function automatic void predict_keying(input logic [mck_pkg::CHAR_W-1:0] c);
    logic [mck_pkg::CHAR_W-1:0] u;
    string                      pat;
    if (c == mck_pkg::CHAR_SPACE) begin
      push_interval(1'b0, timing_reg[mck_pkg::CFG_WORD_GAP], 1'b1);
      at_word_start = 1'b1;
      return;
    end
    u = c;
    if (c >= mck_pkg::CHAR_LOWER_A && c <= mck_pkg::CHAR_LOWER_Z) u = c - mck_pkg::CASE_BIT;
    if (u < mck_pkg::CHAR_UPPER_A || u > mck_pkg::CHAR_UPPER_Z) return;
    pat = morse_tab[u - mck_pkg::CHAR_UPPER_A];
    if (!at_word_start) push_interval(1'b0, timing_reg[mck_pkg::CFG_LETTER_GAP], 1'b0);
    for (int i = 0; i < pat.len(); i++) begin
      if (i != 0) push_interval(1'b0, timing_reg[mck_pkg::CFG_SYMBOL_GAP], 1'b0);
      push_interval(1'b1, (pat[i] == "-") ? timing_reg[mck_pkg::CFG_DASH]
                                          : timing_reg[mck_pkg::CFG_DOT],
                    i == pat.len() - 1);
    end
    at_word_start = 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // hold off the output once a stall is started
  always begin : hold_off
    @(stall_start);
    stall_on <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    stall_on <= 1'b0;
  end

  // hold off the output while stalled, else accept at random or always
  always @(posedge clk) begin
    if (!rst_n) begin
      ivl_chan.ready <= 1'b0;
    end else if (stall_on) begin
      ivl_chan.ready <= 1'b0;
    end else if (idle_on) begin
      ivl_chan.ready <= ($urandom_range(99) >= 20);
    end else begin
      ivl_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_intervals
    interval_t want;
    if (rst_n && ivl_chan.valid && ivl_chan.ready) begin
      if (interval_q.size() == 0) begin
        report_mismatch($sformatf("unexpected interval lamp=%0b units=%0d last=%0b",
                                  ivl_chan.lamp_on, ivl_chan.interval_units,
                                  ivl_chan.last_interval));
      end else begin
        want = interval_q.pop_front();
        if (ivl_chan.lamp_on !== want.lamp_on)
          report_mismatch($sformatf("lamp_on %0b, want %0b", ivl_chan.lamp_on,
                                    want.lamp_on));
        if (ivl_chan.interval_units !== want.units)
          report_mismatch($sformatf("interval_units %0d, want %0d",
                                    ivl_chan.interval_units, want.units));
        if (ivl_chan.last_interval !== want.last)
          report_mismatch($sformatf("last_interval %0b, want %0b",
                                    ivl_chan.last_interval, want.last));
      end
    end
  end

  task automatic send_char(input logic [mck_pkg::CHAR_W-1:0] c);
    while (idle_on && $urandom_range(99) < 20) begin
      char_chan.valid <= 1'b0;
      @(posedge clk);
    end
    char_chan.valid     <= 1'b1;
    char_chan.char_code <= c;
    do @(posedge clk); while (!char_chan.ready);
    predict_keying(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // drop valid, wait for every interval, then let the block settle
  task automatic wait_drain();
    char_chan.valid <= 1'b0;
    @(posedge clk);
    while (interval_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mck_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mck_pkg::UNITS_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx <= mck_pkg::CFG_WORD_GAP) timing_reg[idx] = data;
  endtask

  task automatic write_all(input logic [mck_pkg::UNITS_W-1:0] data);
    for (int i = 0; i < NUM_REGS; i++) write_reg(mck_pkg::CFG_IDX_W'(i), data);
  endtask

  function automatic logic [mck_pkg::CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return ($urandom_range(1) ? mck_pkg::CHAR_LOWER_A : mck_pkg::CHAR_UPPER_A) +
             mck_pkg::CHAR_W'($urandom_range(25));
    if (r < 85) return mck_pkg::CHAR_SPACE;
    return mck_pkg::CHAR_W'($urandom_range(255));
  endfunction

  task automatic test_reset_timing();
    send_text("Et  zQ");
    wait_drain();
  endtask

  task automatic test_char_edges();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h40);
    send_char(8'h5B);
    send_char(8'h60);
    send_char(8'h7B);
    send_char(8'hC1);
    send_char(8'h41);
    send_char(8'h5A);
    send_char(8'h61);
    send_char(8'h7A);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    write_all('0);
    send_text("JO ");
    wait_drain();
    write_all('1);
    send_text("QY");
    wait_drain();
    // out-of-range indexes must leave the timing alone
    for (int i = NUM_REGS; i < (1 << mck_pkg::CFG_IDX_W); i++)
      write_reg(mck_pkg::CFG_IDX_W'(i), '0);
    send_char("R");
    wait_drain();
  endtask

  task automatic test_random_words();
    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < NUM_REGS; i++)
        write_reg(mck_pkg::CFG_IDX_W'(i), mck_pkg::UNITS_W'($urandom_range(15)));
      idle_on = (phase != 2);
      for (int n = 0; n < 40; n++) send_char(random_char());
      wait_drain();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    -> stall_start;
    for (int n = 0; n < 12; n++)
      send_char(mck_pkg::CHAR_UPPER_A + mck_pkg::CHAR_W'($urandom_range(25)));
    wait_drain();
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** morse_code_keyer: FAILED **");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    char_chan.valid     = 1'b0;
    char_chan.char_code = '0;
    idle_on             = 1'b1;
    at_word_start       = 1'b1;
    timing_reg[mck_pkg::CFG_DOT]        = mck_pkg::DOT_RESET;
    timing_reg[mck_pkg::CFG_DASH]       = mck_pkg::DASH_RESET;
    timing_reg[mck_pkg::CFG_SYMBOL_GAP] = mck_pkg::SYMBOL_GAP_RESET;
    timing_reg[mck_pkg::CFG_LETTER_GAP] = mck_pkg::LETTER_GAP_RESET;
    timing_reg[mck_pkg::CFG_WORD_GAP]   = mck_pkg::WORD_GAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_timing();
    test_char_edges();
    test_register_extremes();
    test_random_words();
    test_output_stall();

    if (errors == 0 && interval_q.size() == 0) begin
      $display("** morse_code_keyer: PASSED **");
    end else begin
      $display("** morse_code_keyer: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mck_pkg.sv
rtl/mck_char_if.sv
rtl/mck_interval_if.sv
rtl/mck_dp.sv
rtl/mck_ctrl.sv
rtl/morse_code_keyer.sv
test/morse_code_keyer_tb.sv
